### rtl/keyword_number_lexer_top_assert.svh
// Assertion macros shared by the lexer RTL.
// Every user module has clk_i and rst_ni in scope.
`ifndef KEYWORD_NUMBER_LEXER_TOP_ASSERT_SVH
`define KEYWORD_NUMBER_LEXER_TOP_ASSERT_SVH
`ifndef SYNTH
`define KNL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");
`define KNL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define KNL_ASSERT(lbl, prop)
`define KNL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/knl_pkg.sv
`default_nettype none

package knl_pkg;

  localparam int MaxTokenLength = 255;
  localparam int CntW           = $clog2(MaxTokenLength + 1);
  localparam int BufBytes       = 6;
  localparam int BufW           = 8 * BufBytes;
  localparam int LenSat         = 255;
  localparam int NumTypes       = 5;
  localparam int QDepth         = 4;
  localparam int QAw            = $clog2(QDepth);
  localparam int QCw            = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_IDENT  = 3'b010,
    MODE_NUMBER = 3'b100
  } mode_e;

  typedef enum logic [2:0] {
    TK_IDENT   = 3'd0,
    TK_FUNC    = 3'd1,
    TK_TYPE    = 3'd2,
    TK_INT     = 3'd3,
    TK_FLOAT   = 3'd4,
    TK_PUNCT   = 3'd5,
    TK_NUM_ERR = 3'd6
  } token_kind_e;

  // keywords, first byte in the low lane, zero padded
  localparam logic [BufW-1:0] KwFunc = 48'h0000_636E_7566;
  localparam logic [BufW-1:0] TypeWord [NumTypes] = '{
    48'h0000_0074_6E69,  // int
    48'h0074_616F_6C66,  // float
    48'h0000_6C6F_6F62,  // bool
    48'h0000_7261_6863,  // char
    48'h676E_6972_7473   // string
  };
  localparam int TypeLen [NumTypes] = '{3, 5, 4, 4, 6};

  typedef struct packed {
    token_kind_e kind;
    logic [2:0]  type_code;
    logic [7:0]  punct;
    logic [7:0]  length;
    logic        is_last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [7:0] sat_len(logic [CntW-1:0] n);
    logic [7:0] r;
    if (n > CntW'(LenSat)) begin
      r = 8'(LenSat);
    end else begin
      r = 8'(n);
    end
    return r;
  endfunction

  function automatic res_t flush_res(mode_e m, logic [BufW-1:0] b, logic [CntW-1:0] n,
                                     logic dot, logic err);
    res_t r;
    logic found;
    r = '0;
    found = 1'b0;
    r.length = sat_len(n);
    case (m)
      MODE_IDENT: begin
        if (n == CntW'(4) && b == KwFunc) begin
          r.kind = TK_FUNC;
        end else begin
          for (int t = 0; t < NumTypes; t++) begin
            if (!found && n == CntW'(TypeLen[t]) && b == TypeWord[t]) begin
              found       = 1'b1;
              r.kind      = TK_TYPE;
              r.type_code = 3'(t);
            end
          end
          if (!found) begin
            r.kind = TK_IDENT;
          end
        end
      end
      MODE_NUMBER: begin
        if (err) begin
          r.kind = TK_NUM_ERR;
        end else if (dot) begin
          r.kind = TK_FLOAT;
        end else begin
          r.kind = TK_INT;
        end
      end
      default: r.kind = TK_IDENT;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/knl_if.sv
`default_nettype none

interface knl_chr_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_char;

  modport source (output valid, char_code, final_char, input ready);
  modport sink   (input valid, char_code, final_char, output ready);
endinterface

interface knl_tok_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [2:0] type_code;
  logic [7:0] punct_char;
  logic [7:0] token_length;
  logic       is_last;

  modport source (output valid, token_kind, type_code, punct_char, token_length, is_last,
                  input ready);
  modport sink   (input valid, token_kind, type_code, punct_char, token_length, is_last,
                  output ready);
endinterface

`default_nettype wire

### rtl/knl_core.sv
`default_nettype none
`include "keyword_number_lexer_top_assert.svh"

module knl_core
  import knl_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic       final_char_i,
  output push_t           push_o
);

  mode_e             mode_q, mode_d;
  logic [BufW-1:0]   buf_q, buf_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              dot_q, dot_d;
  logic              err_q, err_d;

  mode_e             m1;
  logic [BufW-1:0]   b1;
  logic [CntW-1:0]   c1;
  logic              d1, e1;
  logic              is_sp, is_lt, is_dg, is_dt;
  logic              cont, term, punct, flush_b;
  res_t              res_a, res_p, res_b;
  push_t             push;

  always_comb begin
    is_sp = (char_code_i == 8'd32) || (char_code_i >= 8'd9 && char_code_i <= 8'd13);
    is_lt = (char_code_i >= 8'd65 && char_code_i <= 8'd90) ||
            (char_code_i >= 8'd97 && char_code_i <= 8'd122);
    is_dg = (char_code_i >= 8'd48 && char_code_i <= 8'd57);
    is_dt = (char_code_i == 8'd46);

    case (mode_q)
      MODE_IDENT: begin
        cont = is_lt | is_dg | is_dt;
        term = !cont;
      end
      MODE_NUMBER: begin
        cont = is_dg | is_dt;
        term = !cont;
      end
      default: begin
        cont = 1'b0;
        term = 1'b0;
      end
    endcase

    res_a = flush_res(mode_q, buf_q, cnt_q, dot_q, err_q);

    m1 = mode_q;
    b1 = buf_q;
    c1 = cnt_q;
    d1 = dot_q;
    e1 = err_q;
    if (cont) begin
      for (int i = 0; i < BufBytes; i++) begin
        if (cnt_q == CntW'(i)) begin
          b1[8*i +: 8] = char_code_i;
        end
      end
      if (cnt_q < CntW'(MaxTokenLength)) begin
        c1 = cnt_q + CntW'(1);
      end
      if (mode_q == MODE_NUMBER && is_dt) begin
        e1 = err_q | dot_q;
        d1 = 1'b1;
      end
    end else if (is_lt || is_dg) begin
      m1 = is_lt ? MODE_IDENT : MODE_NUMBER;
      b1 = BufW'(char_code_i);
      c1 = CntW'(1);
      d1 = 1'b0;
      e1 = 1'b0;
    end else begin
      m1 = MODE_IDLE;
      b1 = '0;
      c1 = '0;
      d1 = 1'b0;
      e1 = 1'b0;
    end

    punct = !cont && !is_sp && !is_lt && !is_dg;
    res_p = '0;
    res_p.kind   = TK_PUNCT;
    res_p.punct  = char_code_i;
    res_p.length = 8'd1;

    flush_b = final_char_i && (m1 == MODE_IDENT || m1 == MODE_NUMBER);
    res_b   = flush_res(m1, b1, c1, d1, e1);

    push = '0;
    if (term) begin
      push.r0 = res_a;
      push.r1 = punct ? res_p : res_b;
      push.n  = (punct || flush_b) ? 2'd2 : 2'd1;
      if (final_char_i) begin
        if (punct || flush_b) begin
          push.r1.is_last = 1'b1;
        end else begin
          push.r0.is_last = 1'b1;
        end
      end
    end else if (punct || flush_b) begin
      push.r0         = punct ? res_p : res_b;
      push.r0.is_last = final_char_i;
      push.n          = 2'd1;
    end
    if (!accept_i) begin
      push.n = 2'd0;
    end

    mode_d = mode_q;
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    dot_d  = dot_q;
    err_d  = err_q;
    if (accept_i) begin
      if (final_char_i) begin
        mode_d = MODE_IDLE;
        buf_d  = '0;
        cnt_d  = '0;
        dot_d  = 1'b0;
        err_d  = 1'b0;
      end else begin
        mode_d = m1;
        buf_d  = b1;
        cnt_d  = c1;
        dot_d  = d1;
        err_d  = e1;
      end
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      buf_q  <= '0;
      cnt_q  <= '0;
      dot_q  <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      buf_q  <= buf_d;
      cnt_q  <= cnt_d;
      dot_q  <= dot_d;
      err_q  <= err_d;
    end
  end

  `KNL_ASSERT(a_two_starts_with_flush,
    push_o.n != 2'd3 && (push_o.n != 2'd2 || push_o.r0.kind != TK_PUNCT))
  `KNL_ASSERT_NEXT(a_final_clears, accept_i && final_char_i,
    mode_q == MODE_IDLE && cnt_q == '0 && buf_q == '0)
  `KNL_ASSERT(a_idle_empty, mode_q != MODE_IDLE || (cnt_q == '0 && !dot_q && !err_q))

endmodule

`default_nettype wire

### rtl/knl_outq.sv
`default_nettype none
`include "keyword_number_lexer_top_assert.svh"

module knl_outq
  import knl_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       room_o,
  knl_tok_if.source  tok_o
);

  res_t             ent_q [QDepth];
  logic [QAw-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCw-1:0]   cnt_q, cnt_d;
  logic             pop;
  res_t             head;

  assign head   = ent_q[rd_q];
  assign pop    = tok_o.valid && tok_o.ready;
  assign room_o = cnt_q <= QCw'(QDepth - 2);

  assign tok_o.valid        = cnt_q != '0;
  assign tok_o.token_kind   = head.kind;
  assign tok_o.type_code    = head.type_code;
  assign tok_o.punct_char   = head.punct;
  assign tok_o.token_length = head.length;
  assign tok_o.is_last      = head.is_last;

  always_comb begin
    wr_d  = wr_q + QAw'(push_i.n);
    rd_d  = rd_q + QAw'(pop);
    cnt_d = cnt_q + QCw'(push_i.n) - QCw'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      ent_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      ent_q[wr_q + QAw'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `KNL_ASSERT(a_no_overfill, cnt_q <= QCw'(QDepth))
  `KNL_ASSERT(a_push_has_room, push_i.n == 2'd0 || cnt_q <= QCw'(QDepth - 2))
  `KNL_ASSERT_NEXT(a_count_tracks, $past(rst_ni) || 1'b1,
    !$past(rst_ni) || cnt_q == $past(cnt_q) + QCw'($past(push_i.n)) - QCw'($past(pop)))

endmodule

`default_nettype wire

### rtl/keyword_number_lexer_top.sv
// Channel | Dir | Modport | Word
// chr_i   | in  | sink    | char_code[7:0], final_char
// tok_o   | out | source  | token_kind[2:0], type_code[2:0], punct_char[7:0],
//         |     |         | token_length[7:0], is_last
//
// One character per cycle is lexed in a single pass while chr_i.ready is high; its
// tokens (0 to 2) land in a 4-word output queue at the edge that takes the byte, and
// the first of them can show on tok_o in the cycle after. chr_i.ready is high while
// the queue holds at most two words, so input goes on through short tok_o stalls and
// stops once three or more words wait; throughput is one byte a cycle when each byte
// yields at most one token and tok_o is ready, else the one-word-per-cycle read bounds it.
// rst_ni (async, active low) clears the lexer state and empties the queue.
`default_nettype none

module keyword_number_lexer_top
  import knl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  knl_chr_if.sink   chr_i,
  knl_tok_if.source tok_o
);

  push_t push;
  logic  room;
  logic  accept;

  assign chr_i.ready = room;
  assign accept      = chr_i.valid && room;

  knl_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .char_code_i  (chr_i.char_code),
    .final_char_i (chr_i.final_char),
    .push_o       (push)
  );

  knl_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .tok_o  (tok_o)
  );

endmodule

`default_nettype wire

### sim/tb_keyword_number_lexer_top.sv
`timescale 1ns / 1ps

module tb_keyword_number_lexer_top;
  import knl_pkg::*;

  logic clk;
  logic rst_n;

  knl_chr_if chr ();
  knl_tok_if tok ();

  keyword_number_lexer_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .chr_i (chr),
    .tok_o (tok)
  );

  // lexer state tracked by the testbench
  mode_e       lx_mode = MODE_IDLE;
  logic [47:0] lx_buf  = '0;
  logic [7:0]  lx_cnt  = '0;
  logic        lx_dot  = 1'b0;
  logic        lx_err  = 1'b0;

  res_t pending_tokens[$];
  int   mismatches = 0;
  int   chars_sent = 0;
  bit   quiet      = 1'b0;
  int   hold_req   = 0;

  string kw_words[6]   = '{"func", "int", "float", "bool", "char", "string"};
  string type_words[5] = '{"int", "float", "bool", "char", "string"};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [47:0] word_bits(string s);
    logic [47:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 6; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  function automatic void start_word(mode_e m, logic [7:0] c);
    lx_mode = m;
    lx_buf  = 48'(c);
    lx_cnt  = 8'd1;
    lx_dot  = 1'b0;
    lx_err  = 1'b0;
  endfunction

  function automatic void grow_word(logic [7:0] c);
    if (lx_cnt < 8'd6) lx_buf[8*lx_cnt +: 8] = c;
    if (lx_cnt < 8'(MaxTokenLength)) lx_cnt++;
  endfunction

  function automatic void close_word(ref res_t out[$]);
    res_t r;
    r = '0;
    r.length = lx_cnt;
    if (lx_mode == MODE_IDENT) begin
      r.kind = TK_IDENT;
      if (lx_cnt == 8'd4 && lx_buf == word_bits("func")) begin
        r.kind = TK_FUNC;
      end else begin
        for (int t = 0; t < 5; t++) begin
          if (r.kind == TK_IDENT && lx_cnt == 8'(type_words[t].len()) &&
              lx_buf == word_bits(type_words[t])) begin
            r.kind      = TK_TYPE;
            r.type_code = 3'(t);
          end
        end
      end
    end else if (lx_mode == MODE_NUMBER) begin
      r.kind = lx_err ? TK_NUM_ERR : (lx_dot ? TK_FLOAT : TK_INT);
    end else begin
      return;
    end
    out = {out, r};
    lx_mode = MODE_IDLE;
    lx_buf  = '0;
    lx_cnt  = '0;
    lx_dot  = 1'b0;
    lx_err  = 1'b0;
  endfunction

  function automatic void lex_fresh(logic [7:0] c, ref res_t out[$]);
    res_t r;
    if (is_ws(c)) return;
    if (is_alpha(c)) begin
      start_word(MODE_IDENT, c);
    end else if (is_num(c)) begin
      start_word(MODE_NUMBER, c);
    end else begin
      r        = '0;
      r.kind   = TK_PUNCT;
      r.punct  = c;
      r.length = 8'd1;
      out = {out, r};
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c, logic fin);
    res_t out[$];
    if (lx_mode == MODE_IDENT) begin
      if (is_alpha(c) || is_num(c) || c == ".") begin
        grow_word(c);
      end else begin
        close_word(out);
        lex_fresh(c, out);
      end
    end else if (lx_mode == MODE_NUMBER) begin
      if (is_num(c)) begin
        grow_word(c);
      end else if (c == ".") begin
        if (lx_dot) lx_err = 1'b1;
        lx_dot = 1'b1;
        grow_word(c);
      end else begin
        close_word(out);
        lex_fresh(c, out);
      end
    end else begin
      lex_fresh(c, out);
    end
    if (fin) begin
      close_word(out);
      if (out.size() > 0) out[out.size()-1].is_last = 1'b1;
    end
    pending_tokens = {pending_tokens, out};
  endfunction

  // token checker
  always @(posedge clk) begin : check_tokens
    res_t want;
    if (rst_n && tok.valid && tok.ready) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected token: kind %0d type %0d punct %0d len %0d last %0d",
                 $time, tok.token_kind, tok.type_code, tok.punct_char, tok.token_length,
                 tok.is_last);
      end else begin
        want = pending_tokens.pop_front();
        if (tok.token_kind !== want.kind || tok.type_code !== want.type_code ||
            tok.punct_char !== want.punct || tok.token_length !== want.length ||
            tok.is_last !== want.is_last) begin
          mismatches++;
          $display("%0t: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                   $time, want.kind, want.type_code, want.punct, want.length, want.is_last,
                   tok.token_kind, tok.type_code, tok.punct_char, tok.token_length,
                   tok.is_last);
        end
      end
    end
  end

  // token sink with random stalls and requested hold-offs
  initial begin : token_sink
    int hold_left;
    hold_left = 0;
    tok.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        tok.ready = 1'b0;
        hold_left--;
      end else begin
        tok.ready = quiet ? 1'b1 : ($urandom_range(99) >= 10);
      end
    end
  end

  task automatic send_byte(logic [7:0] c, logic fin);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 10) begin
      chr.valid = 1'b0;
      @(negedge clk);
    end
    chr.valid      = 1'b1;
    chr.char_code  = c;
    chr.final_char = fin;
    @(posedge clk);
    while (!chr.ready) @(posedge clk);
    lex_byte(c, fin);
    chars_sent++;
  endtask

  task automatic send_text(string s, bit fin_at_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin_at_end && i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'("a" + $urandom_range(25));
    if ($urandom_range(1)) c = c - 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] rand_ws();
    logic [7:0] c;
    c = 8'($urandom_range(9, 14));
    return (c == 8'd14) ? 8'd32 : c;
  endfunction

  function automatic logic [7:0] rand_punct();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (is_alpha(c) || is_num(c) || is_ws(c)) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic bit rand_fin();
    return $urandom_range(99) < 3;
  endfunction

  task automatic test_directed();
    send_text("func(string\t9.1.2x7.5;", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_text("Q ", 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_final_flush();
    send_byte(8'd10, 1'b1);
    send_text("a1", 1'b1);
    send_text("3;", 1'b1);
    send_text("FUNC", 1'b1);
  endtask

  task automatic test_long_tokens();
    send_text("strings floats ", 1'b0);
    send_byte("w", 1'b0);
    for (int i = 0; i < 257; i++) send_byte(rand_letter(), 1'b0);
    send_byte("+", 1'b0);
    for (int i = 0; i < 256; i++) send_byte((i == 100) ? 8'(".") : 8'("7"), 1'b0);
    send_byte(" ", 1'b1);
  endtask

  task automatic test_backpressure();
    quiet    = 1'b1;
    hold_req = 80;
    for (int i = 0; i < 40; i++) send_byte((i % 3 == 0) ? rand_letter() : rand_punct(), 1'b0);
    quiet = 1'b0;
  endtask

  task automatic test_random(int target);
    int    n;
    int    r;
    int    base;
    string w;
    base = chars_sent;
    while (chars_sent < target) begin
      quiet = (chars_sent < base + 350);
      r = $urandom_range(99);
      if (r < 15) begin
        send_byte(8'($urandom_range(255)), rand_fin());
      end else if (r < 35) begin
        w = kw_words[$urandom_range(5)];
        for (int i = 0; i < w.len(); i++) send_byte(w[i], rand_fin());
      end else if (r < 55) begin
        send_byte(rand_letter(), rand_fin());
        n = $urandom_range(8);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(9);
          send_byte((r < 6) ? rand_letter() : (r < 9) ? 8'("0" + $urandom_range(9)) : 8'("."),
                    rand_fin());
        end
      end else if (r < 75) begin
        send_byte(8'("0" + $urandom_range(9)), rand_fin());
        n = $urandom_range(7);
        for (int i = 0; i < n; i++)
          send_byte(($urandom_range(99) < 85) ? 8'("0" + $urandom_range(9)) : 8'("."),
                    rand_fin());
      end else begin
        send_byte(rand_punct(), rand_fin());
      end
      r = $urandom_range(99);
      if (r < 60) send_byte(rand_ws(), rand_fin());
      else if (r < 80) send_byte(rand_punct(), rand_fin());
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    chr.valid      = 1'b0;
    chr.char_code  = '0;
    chr.final_char = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_final_flush();
    test_long_tokens();
    test_backpressure();
    test_random(1150);

    @(negedge clk);
    chr.valid = 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
